### design/ring_wave_pixel_generator_macros.svh
// assertion macros for the ring wave pixel generator
// expects clk and rst_n in the scope where the macros are used
`ifndef RING_WAVE_PIXEL_GENERATOR_MACROS_SVH
`define RING_WAVE_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication
`define RWPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RWPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rwpg_pkg.sv
// shared types, constants and microcode rom of the ring wave pixel generator
// no dependencies
`default_nettype none

package rwpg_pkg;

  localparam int LED_COUNT_W  = 7;
  localparam int INTERVAL_W   = 16;
  localparam int LEVEL_W      = 8;
  localparam int COLOR_W      = 8;
  localparam int IDX_OUT_W    = 6;
  localparam int PROD_W       = 2 * COLOR_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_PEAK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_NEAR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MID      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_RED       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_GREEN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_BLUE      = 3'd7;

  // register reset values
  localparam logic [LED_COUNT_W-1:0] RST_LED_COUNT      = 7'd64;
  localparam logic [INTERVAL_W-1:0]  RST_FRAME_INTERVAL = 16'd50;
  localparam logic [LEVEL_W-1:0]     RST_LEVEL_PEAK     = 8'd255;
  localparam logic [LEVEL_W-1:0]     RST_LEVEL_NEAR     = 8'd200;
  localparam logic [LEVEL_W-1:0]     RST_LEVEL_MID      = 8'd50;
  localparam logic [COLOR_W-1:0]     RST_WAVE_RED       = 8'd0;
  localparam logic [COLOR_W-1:0]     RST_WAVE_GREEN     = 8'd255;
  localparam logic [COLOR_W-1:0]     RST_WAVE_BLUE      = 8'd255;

  // fixed falloff levels
  localparam logic [LEVEL_W-1:0] LEVEL_DIST2 = 8'd150;
  localparam logic [LEVEL_W-1:0] LEVEL_DIST3 = 8'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_DIST5 = 8'd30;
  localparam logic [LEVEL_W-1:0] LEVEL_DIST6 = 8'd15;
  localparam logic [LEVEL_W-1:0] LEVEL_FAR   = 8'd5;
  localparam int                 DIST_FAR    = 7;

  typedef struct packed {
    logic [LED_COUNT_W-1:0] led_count;
    logic [INTERVAL_W-1:0]  frame_interval;
    logic [LEVEL_W-1:0]     level_peak;
    logic [LEVEL_W-1:0]     level_near;
    logic [LEVEL_W-1:0]     level_mid;
    logic [COLOR_W-1:0]     wave_red;
    logic [COLOR_W-1:0]     wave_green;
    logic [COLOR_W-1:0]     wave_blue;
  } cfg_t;

  // datapath strobes, already qualified by the sequencer
  typedef struct packed {
    logic accept;
    logic setup;
    logic mult;
    logic emit;
    logic advance;
  } dp_ctrl_t;

  typedef struct packed {
    logic fire;
    logic last;
    logic out_busy;
  } dp_stat_t;

  // microcode
  localparam int STEP_W = 3;

  localparam logic [STEP_W-1:0] STEP_FETCH   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SETUP   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MULT    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_EMIT    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_ADVANCE = 3'd4;

  localparam logic [1:0] HOLD_NONE = 2'd0;
  localparam logic [1:0] HOLD_IN   = 2'd1;
  localparam logic [1:0] HOLD_OUT  = 2'd2;

  localparam logic [1:0] BR_NEVER   = 2'd0;
  localparam logic [1:0] BR_NOFIRE  = 2'd1;
  localparam logic [1:0] BR_NOTLAST = 2'd2;
  localparam logic [1:0] BR_ALWAYS  = 2'd3;

  typedef struct packed {
    logic              accept;
    logic              setup;
    logic              mult;
    logic              emit;
    logic              advance;
    logic [1:0]        hold_sel;
    logic [1:0]        br_sel;
    logic [STEP_W-1:0] target;
  } ucw_t;

  function automatic ucw_t ucode_rom(input logic [STEP_W-1:0] step);
    ucw_t w;
    w = '0;
    case (step)
      STEP_FETCH: begin
        w.accept   = 1'b1;
        w.hold_sel = HOLD_IN;
        w.br_sel   = BR_NOFIRE;
        w.target   = STEP_FETCH;
      end
      STEP_SETUP: begin
        w.setup  = 1'b1;
        w.br_sel = BR_NEVER;
      end
      STEP_MULT: begin
        w.mult   = 1'b1;
        w.br_sel = BR_NEVER;
      end
      STEP_EMIT: begin
        w.emit     = 1'b1;
        w.hold_sel = HOLD_OUT;
        w.br_sel   = BR_NOTLAST;
        w.target   = STEP_MULT;
      end
      STEP_ADVANCE: begin
        w.advance = 1'b1;
        w.br_sel  = BR_ALWAYS;
        w.target  = STEP_FETCH;
      end
      default: begin
        w.br_sel = BR_ALWAYS;
        w.target = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### design/rwpg_ifs.sv
// valid/ready channel interfaces: tick input, pixel output, register writes
// depends on rwpg_pkg
`default_nettype none

interface rwpg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface rwpg_out_if;
  logic                            valid;
  logic                            ready;
  logic [rwpg_pkg::IDX_OUT_W-1:0]  pixel_index;
  logic [rwpg_pkg::COLOR_W-1:0]    pixel_red;
  logic [rwpg_pkg::COLOR_W-1:0]    pixel_green;
  logic [rwpg_pkg::COLOR_W-1:0]    pixel_blue;
  logic                            frame_end;
  modport source (output valid, output pixel_index, output pixel_red, output pixel_green,
                  output pixel_blue, output frame_end, input ready);
  modport sink (input valid, input pixel_index, input pixel_red, input pixel_green,
                input pixel_blue, input frame_end, output ready);
endinterface

interface rwpg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rwpg_pkg::CFG_IDX_W-1:0]   index;
  logic [rwpg_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/ring_wave_pixel_generator.sv
// ring wave pixel generator top: register file, sequencer and datapath
// depends on rwpg_pkg, rwpg_ifs, rwpg_useq, rwpg_datapath and the macros header
//
// channel  dir  word                                           handshake
// in_ch    in   restart                                        valid/ready
// out_ch   out  pixel_index, red, green, blue, frame_end       valid/ready
// cfg_ch   in   index, data                                    valid/ready, ready always high
//
// a tick that fires no frame keeps the sequencer in its fetch step, ready for the next
// tick; a fired frame holds off new ticks until its pixel loop and position step are done,
// with the two-step pixel loop (distance and multiply, then scale and load) per led
// an output stall holds the sequencer in its load step; reset is synchronous: it clears
// the sequencer, output valid and position, saturates the tick count and loads register reset values
`default_nettype none

`include "ring_wave_pixel_generator_macros.svh"

module ring_wave_pixel_generator #(
  parameter int MAX_LEDS = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  rwpg_in_if.sink    in_ch,
  rwpg_out_if.source out_ch,
  rwpg_cfg_if.sink   cfg_ch
);

  rwpg_pkg::cfg_t     cfg_r;
  rwpg_pkg::dp_ctrl_t ctl;
  rwpg_pkg::dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_count      <= rwpg_pkg::RST_LED_COUNT;
      cfg_r.frame_interval <= rwpg_pkg::RST_FRAME_INTERVAL;
      cfg_r.level_peak     <= rwpg_pkg::RST_LEVEL_PEAK;
      cfg_r.level_near     <= rwpg_pkg::RST_LEVEL_NEAR;
      cfg_r.level_mid      <= rwpg_pkg::RST_LEVEL_MID;
      cfg_r.wave_red       <= rwpg_pkg::RST_WAVE_RED;
      cfg_r.wave_green     <= rwpg_pkg::RST_WAVE_GREEN;
      cfg_r.wave_blue      <= rwpg_pkg::RST_WAVE_BLUE;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        rwpg_pkg::CFG_LED_COUNT:
          cfg_r.led_count <= cfg_ch.data[rwpg_pkg::LED_COUNT_W-1:0];
        rwpg_pkg::CFG_FRAME_INTERVAL:
          cfg_r.frame_interval <= cfg_ch.data[rwpg_pkg::INTERVAL_W-1:0];
        rwpg_pkg::CFG_LEVEL_PEAK:
          cfg_r.level_peak <= cfg_ch.data[rwpg_pkg::LEVEL_W-1:0];
        rwpg_pkg::CFG_LEVEL_NEAR:
          cfg_r.level_near <= cfg_ch.data[rwpg_pkg::LEVEL_W-1:0];
        rwpg_pkg::CFG_LEVEL_MID:
          cfg_r.level_mid <= cfg_ch.data[rwpg_pkg::LEVEL_W-1:0];
        rwpg_pkg::CFG_WAVE_RED:
          cfg_r.wave_red <= cfg_ch.data[rwpg_pkg::COLOR_W-1:0];
        rwpg_pkg::CFG_WAVE_GREEN:
          cfg_r.wave_green <= cfg_ch.data[rwpg_pkg::COLOR_W-1:0];
        rwpg_pkg::CFG_WAVE_BLUE:
          cfg_r.wave_blue <= cfg_ch.data[rwpg_pkg::COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rwpg_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .ctl      (ctl),
    .in_ready (in_ch.ready)
  );

  rwpg_datapath #(
    .MAX_LEDS (MAX_LEDS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .restart     (in_ch.restart),
    .ctl         (ctl),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .pixel_index (out_ch.pixel_index),
    .pixel_red   (out_ch.pixel_red),
    .pixel_green (out_ch.pixel_green),
    .pixel_blue  (out_ch.pixel_blue),
    .frame_end   (out_ch.frame_end)
  );

  // a loaded pixel word is offered on the next cycle
  `RWPG_ASSERT_NEXT(a_emit_shows, ctl.emit, out_ch.valid, "loaded pixel word not offered")
  // a restart tick always starts a frame
  `RWPG_ASSERT_NEXT(a_restart_fires, in_ch.valid && in_ch.ready && in_ch.restart, ctl.setup,
    "restart tick did not start a frame")
  // the position only moves while the last pixel word of the frame is offered
  `RWPG_ASSERT_NOW(a_advance_after_end, ctl.advance, out_ch.valid && out_ch.frame_end,
    "position advanced without a frame end word")

endmodule

`default_nettype wire

### design/rwpg_useq.sv
// microcoded sequencer: step counter, control rom and conditional jumps
// depends on rwpg_pkg
`default_nettype none

module rwpg_useq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire rwpg_pkg::dp_stat_t stat,
  output rwpg_pkg::dp_ctrl_t      ctl,
  output logic                    in_ready
);

  logic [rwpg_pkg::STEP_W-1:0] step_r;
  logic [rwpg_pkg::STEP_W-1:0] step_nxt;
  rwpg_pkg::ucw_t              uw;
  logic                        hold;
  logic                        take_br;

  assign uw = rwpg_pkg::ucode_rom(step_r);

  always_comb begin
    case (uw.hold_sel)
      rwpg_pkg::HOLD_IN:  hold = !in_valid;
      rwpg_pkg::HOLD_OUT: hold = stat.out_busy;
      default:            hold = 1'b0;
    endcase
    case (uw.br_sel)
      rwpg_pkg::BR_NOFIRE:  take_br = !stat.fire;
      rwpg_pkg::BR_NOTLAST: take_br = !stat.last;
      rwpg_pkg::BR_ALWAYS:  take_br = 1'b1;
      default:              take_br = 1'b0;
    endcase
    if (hold) begin
      step_nxt = step_r;
    end else if (take_br) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  assign in_ready    = uw.accept;
  assign ctl.accept  = uw.accept & !hold;
  assign ctl.setup   = uw.setup & !hold;
  assign ctl.mult    = uw.mult & !hold;
  assign ctl.emit    = uw.emit & !hold;
  assign ctl.advance = uw.advance & !hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= rwpg_pkg::STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

### design/rwpg_datapath.sv
// datapath: tick counter, wave position, ring distance, falloff, color scaling
// and the output register; depends on rwpg_pkg
`default_nettype none

module rwpg_datapath #(
  parameter int MAX_LEDS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire rwpg_pkg::cfg_t                 cfg,
  input  wire logic                           restart,
  input  wire rwpg_pkg::dp_ctrl_t             ctl,
  output rwpg_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rwpg_pkg::IDX_OUT_W-1:0]      pixel_index,
  output logic [rwpg_pkg::COLOR_W-1:0]        pixel_red,
  output logic [rwpg_pkg::COLOR_W-1:0]        pixel_green,
  output logic [rwpg_pkg::COLOR_W-1:0]        pixel_blue,
  output logic                                frame_end
);

  localparam int PW = $clog2(MAX_LEDS);
  localparam int CW = $clog2(MAX_LEDS + 1);
  localparam int DW = CW + 1;
  localparam int TW = rwpg_pkg::INTERVAL_W;
  localparam int XW = rwpg_pkg::PROD_W + 1;

  logic [TW-1:0] ticks_r, ticks_nxt, ticks_inc;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          fire;
  logic          last;

  logic [rwpg_pkg::PROD_W-1:0] prod_red_r, prod_green_r, prod_blue_r;
  logic [PW-1:0]               pidx_r;
  logic                        plast_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [PW-1:0]                 oidx_r;
  logic [rwpg_pkg::COLOR_W-1:0]  ored_r, ogreen_r, oblue_r;
  logic                          oend_r;
  logic                          out_busy;
  logic                          load_out;

  logic [DW-1:0]                 d_raw;
  logic [CW-1:0]                 d_ring, ring_dist;
  logic [31:0]                   dist32;
  logic [2:0]                    dsel;
  logic [rwpg_pkg::LEVEL_W-1:0]  level;
  logic [31:0]                   lc32;
  logic [XW-1:0]                 q_red, q_green, q_blue;
  logic [31:0]                   oidx32;

  // tick counting
  assign ticks_inc = (ticks_r == '1) ? ticks_r : ticks_r + 1'b1;
  assign fire      = restart || (ticks_inc >= cfg.frame_interval);

  // led count in use, clamped to 1..MAX_LEDS
  assign lc32 = 32'(cfg.led_count);
  always_comb begin
    if (lc32 == 0) begin
      n_nxt = CW'(1);
    end else if (lc32 > MAX_LEDS) begin
      n_nxt = CW'(MAX_LEDS);
    end else begin
      n_nxt = CW'(lc32);
    end
  end

  // shortest ring distance
  always_comb begin
    d_raw     = DW'(idx_r) + ((idx_r < pos_r) ? DW'(n_r) : DW'(0)) - DW'(pos_r);
    d_ring    = d_raw[CW-1:0];
    ring_dist = (d_ring > (n_r >> 1)) ? (n_r - d_ring) : d_ring;
    dist32    = 32'(ring_dist);
    dsel      = (dist32 >= rwpg_pkg::DIST_FAR) ? 3'd7 : dist32[2:0];
    case (dsel)
      3'd0:    level = cfg.level_peak;
      3'd1:    level = cfg.level_near;
      3'd2:    level = rwpg_pkg::LEVEL_DIST2;
      3'd3:    level = rwpg_pkg::LEVEL_DIST3;
      3'd4:    level = cfg.level_mid;
      3'd5:    level = rwpg_pkg::LEVEL_DIST5;
      3'd6:    level = rwpg_pkg::LEVEL_DIST6;
      default: level = rwpg_pkg::LEVEL_FAR;
    endcase
  end

  // divide by 255: (p + (p >> 8) + 1) >> 8, exact for 8-bit by 8-bit products
  assign q_red   = XW'(prod_red_r) + XW'(prod_red_r >> 8) + XW'(1);
  assign q_green = XW'(prod_green_r) + XW'(prod_green_r >> 8) + XW'(1);
  assign q_blue  = XW'(prod_blue_r) + XW'(prod_blue_r >> 8) + XW'(1);

  assign last     = plast_r;
  assign out_busy = out_valid_r && !out_ready;
  assign load_out = ctl.emit;

  always_comb begin
    ticks_nxt = ticks_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    if (ctl.accept) begin
      if (restart) begin
        pos_nxt   = '0;
        ticks_nxt = '0;
      end else begin
        ticks_nxt = fire ? '0 : ticks_inc;
      end
    end
    if (ctl.setup) begin
      idx_nxt = '0;
      if (CW'(pos_r) >= n_nxt) begin
        pos_nxt = '0;
      end
    end
    if (ctl.emit) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (ctl.advance) begin
      pos_nxt = ((CW'(pos_r) + 1'b1) >= n_r) ? '0 : pos_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r     <= '1;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ticks_r     <= ticks_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctl.setup) begin
      n_r <= n_nxt;
    end
    if (ctl.mult) begin
      prod_red_r   <= cfg.wave_red * level;
      prod_green_r <= cfg.wave_green * level;
      prod_blue_r  <= cfg.wave_blue * level;
      pidx_r       <= idx_r;
      plast_r      <= ((CW'(idx_r) + 1'b1) == n_r);
    end
    if (load_out) begin
      oidx_r   <= pidx_r;
      ored_r   <= q_red[15:8];
      ogreen_r <= q_green[15:8];
      oblue_r  <= q_blue[15:8];
      oend_r   <= plast_r;
    end
  end

  assign oidx32      = 32'(oidx_r);
  assign out_valid   = out_valid_r;
  assign pixel_index = oidx32[rwpg_pkg::IDX_OUT_W-1:0];
  assign pixel_red   = ored_r;
  assign pixel_green = ogreen_r;
  assign pixel_blue  = oblue_r;
  assign frame_end   = oend_r;

  assign stat.fire     = fire;
  assign stat.last     = last;
  assign stat.out_busy = out_busy;

endmodule

`default_nettype wire

### dv/tb_ring_wave_pixel_generator.sv
// testbench for ring_wave_pixel_generator: drives ticks and register writes,
// predicts every pixel word of each frame and checks it field by field
// depends on rwpg_pkg, rwpg_ifs and the ring_wave_pixel_generator rtl
`default_nettype none

module tb_ring_wave_pixel_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_MAX      = 64;
  localparam int STIM_ITEMS    = 450;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 12;
  localparam int IDLE_LIMIT    = 2000;

  typedef struct packed {
    logic [rwpg_pkg::IDX_OUT_W-1:0] pixel_index;
    logic [rwpg_pkg::COLOR_W-1:0]   pixel_red;
    logic [rwpg_pkg::COLOR_W-1:0]   pixel_green;
    logic [rwpg_pkg::COLOR_W-1:0]   pixel_blue;
    logic                           frame_end;
  } pixel_t;

  class wave_frame_board;
    rwpg_pkg::cfg_t regs;
    logic [15:0]    ticks;
    int             pos;
    pixel_t         pending_pixels[$];
    int             mismatches;

    function new();
      regs.led_count      = rwpg_pkg::RST_LED_COUNT;
      regs.frame_interval = rwpg_pkg::RST_FRAME_INTERVAL;
      regs.level_peak     = rwpg_pkg::RST_LEVEL_PEAK;
      regs.level_near     = rwpg_pkg::RST_LEVEL_NEAR;
      regs.level_mid      = rwpg_pkg::RST_LEVEL_MID;
      regs.wave_red       = rwpg_pkg::RST_WAVE_RED;
      regs.wave_green     = rwpg_pkg::RST_WAVE_GREEN;
      regs.wave_blue      = rwpg_pkg::RST_WAVE_BLUE;
      ticks      = 16'hFFFF;
      pos        = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [rwpg_pkg::CFG_IDX_W-1:0] idx,
                            logic [rwpg_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        rwpg_pkg::CFG_LED_COUNT:
          regs.led_count = data[rwpg_pkg::LED_COUNT_W-1:0];
        rwpg_pkg::CFG_FRAME_INTERVAL:
          regs.frame_interval = data[rwpg_pkg::INTERVAL_W-1:0];
        rwpg_pkg::CFG_LEVEL_PEAK:
          regs.level_peak = data[rwpg_pkg::LEVEL_W-1:0];
        rwpg_pkg::CFG_LEVEL_NEAR:
          regs.level_near = data[rwpg_pkg::LEVEL_W-1:0];
        rwpg_pkg::CFG_LEVEL_MID:
          regs.level_mid = data[rwpg_pkg::LEVEL_W-1:0];
        rwpg_pkg::CFG_WAVE_RED:
          regs.wave_red = data[rwpg_pkg::COLOR_W-1:0];
        rwpg_pkg::CFG_WAVE_GREEN:
          regs.wave_green = data[rwpg_pkg::COLOR_W-1:0];
        rwpg_pkg::CFG_WAVE_BLUE:
          regs.wave_blue = data[rwpg_pkg::COLOR_W-1:0];
        default: begin
        end
      endcase
    endfunction

    function logic [rwpg_pkg::LEVEL_W-1:0] level_at(int ring_dist);
      case (ring_dist)
        0:       return regs.level_peak;
        1:       return regs.level_near;
        2:       return rwpg_pkg::LEVEL_DIST2;
        3:       return rwpg_pkg::LEVEL_DIST3;
        4:       return regs.level_mid;
        5:       return rwpg_pkg::LEVEL_DIST5;
        6:       return rwpg_pkg::LEVEL_DIST6;
        default: return rwpg_pkg::LEVEL_FAR;
      endcase
    endfunction

    function logic [rwpg_pkg::COLOR_W-1:0] dim(logic [rwpg_pkg::COLOR_W-1:0] c,
                                               logic [rwpg_pkg::LEVEL_W-1:0] lvl);
      int q;
      q = (int'(c) * int'(lvl)) / 255;
      return q[rwpg_pkg::COLOR_W-1:0];
    endfunction

    function void take_tick(logic restart);
      bit                           fire;
      int                           n;
      int                           ring_dist;
      logic [rwpg_pkg::LEVEL_W-1:0] lvl;
      pixel_t                       px;
      if (restart) begin
        pos  = 0;
        fire = 1'b1;
      end else begin
        if (ticks != 16'hFFFF) ticks++;
        fire = (ticks >= regs.frame_interval);
      end
      if (!fire) return;
      ticks = '0;
      n = int'(regs.led_count);
      if (n < 1) n = 1;
      if (n > RING_MAX) n = RING_MAX;
      if (pos >= n) pos = 0;
      for (int i = 0; i < n; i++) begin
        ring_dist = (i >= pos) ? (i - pos) : (i + n - pos);
        if (ring_dist > n / 2) ring_dist = n - ring_dist;
        lvl = level_at(ring_dist);
        px.pixel_index = i[rwpg_pkg::IDX_OUT_W-1:0];
        px.pixel_red   = dim(regs.wave_red, lvl);
        px.pixel_green = dim(regs.wave_green, lvl);
        px.pixel_blue  = dim(regs.wave_blue, lvl);
        px.frame_end   = (i == n - 1);
        pending_pixels.push_back(px);
      end
      pos++;
      if (pos >= n) pos = 0;
    endfunction

    function void cmp_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void match_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected pixel word: expected none actual index %0d",
                 $time, got.pixel_index);
        mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      cmp_field("pixel_index", want.pixel_index, got.pixel_index);
      cmp_field("pixel_red", want.pixel_red, got.pixel_red);
      cmp_field("pixel_green", want.pixel_green, got.pixel_green);
      cmp_field("pixel_blue", want.pixel_blue, got.pixel_blue);
      cmp_field("frame_end", want.frame_end, got.frame_end);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rwpg_in_if  in_ch();
  rwpg_out_if out_ch();
  rwpg_cfg_if cfg_ch();

  ring_wave_pixel_generator #(
    .MAX_LEDS(RING_MAX)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  wave_frame_board board;
  int in_idle_max  = 17;
  int out_idle_max = 17;
  int idle_cycles  = 0;
  int sent         = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial board = new();

  // monitor and watchdog
  always @(posedge clk) begin
    pixel_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.pixel_index = out_ch.pixel_index;
        got.pixel_red   = out_ch.pixel_red;
        got.pixel_green = out_ch.pixel_green;
        got.pixel_blue  = out_ch.pixel_blue;
        got.frame_end   = out_ch.frame_end;
        board.match_pixel(got);
      end
      if (in_ch.valid && in_ch.ready) board.take_tick(in_ch.restart);
      if (cfg_ch.valid && cfg_ch.ready) board.write_reg(cfg_ch.index, cfg_ch.data);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("ring_wave_pixel_generator verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // pixel receiver with random stalls
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, out_idle_max);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_tick(logic rs);
    int gap;
    gap = $urandom_range(0, in_idle_max);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.restart = rs;
    in_ch.valid   = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(logic [rwpg_pkg::CFG_IDX_W-1:0] idx,
                           logic [rwpg_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (board.pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // random upper bits above the field width now and then
  function automatic logic [rwpg_pkg::CFG_DATA_W-1:0] with_junk(int width, int value);
    logic [31:0] d;
    d = $urandom;
    if ($urandom_range(0, 3) != 0) d = '0;
    d = (d << width) | value;
    return d[rwpg_pkg::CFG_DATA_W-1:0];
  endfunction

  function automatic int pick_byte();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic shuffle_config(bit every);
    int v;
    if (every || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 11))
        0:       v = 0;
        1:       v = RING_MAX;
        2:       v = $urandom_range(RING_MAX + 1, 127);
        3, 4:    v = $urandom_range(9, 20);
        default: v = $urandom_range(1, 8);
      endcase
      write_reg(rwpg_pkg::CFG_LED_COUNT, with_junk(rwpg_pkg::LED_COUNT_W, v));
    end
    if (every || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0:       v = 0;
        1:       v = 65535;
        2:       v = $urandom_range(6, 40);
        default: v = $urandom_range(1, 4);
      endcase
      write_reg(rwpg_pkg::CFG_FRAME_INTERVAL, with_junk(rwpg_pkg::INTERVAL_W, v));
    end
    if (every || $urandom_range(0, 1))
      write_reg(rwpg_pkg::CFG_LEVEL_PEAK, with_junk(rwpg_pkg::LEVEL_W, pick_byte()));
    if (every || $urandom_range(0, 1))
      write_reg(rwpg_pkg::CFG_LEVEL_NEAR, with_junk(rwpg_pkg::LEVEL_W, pick_byte()));
    if (every || $urandom_range(0, 1))
      write_reg(rwpg_pkg::CFG_LEVEL_MID, with_junk(rwpg_pkg::LEVEL_W, pick_byte()));
    if (every || $urandom_range(0, 1))
      write_reg(rwpg_pkg::CFG_WAVE_RED, with_junk(rwpg_pkg::COLOR_W, pick_byte()));
    if (every || $urandom_range(0, 1))
      write_reg(rwpg_pkg::CFG_WAVE_GREEN, with_junk(rwpg_pkg::COLOR_W, pick_byte()));
    if (every || $urandom_range(0, 1))
      write_reg(rwpg_pkg::CFG_WAVE_BLUE, with_junk(rwpg_pkg::COLOR_W, pick_byte()));
  endtask

  initial begin
    int phase;
    int phase_len;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = rwpg_pkg::CFG_LED_COUNT;
    cfg_ch.data   = '0;
    rst_n         = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // saturated count fires even at the largest interval, then only restart
    write_reg(rwpg_pkg::CFG_FRAME_INTERVAL, 16'hFFFF);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();

    // zero interval, led count zero, extreme levels and colors
    write_reg(rwpg_pkg::CFG_FRAME_INTERVAL, 16'h0000);
    write_reg(rwpg_pkg::CFG_LED_COUNT, 16'h0000);
    write_reg(rwpg_pkg::CFG_WAVE_RED, 16'h00FF);
    write_reg(rwpg_pkg::CFG_WAVE_GREEN, 16'hFF00);
    write_reg(rwpg_pkg::CFG_WAVE_BLUE, 16'h0080);
    write_reg(rwpg_pkg::CFG_LEVEL_PEAK, 16'h0000);
    write_reg(rwpg_pkg::CFG_LEVEL_NEAR, 16'hFFFF);
    write_reg(rwpg_pkg::CFG_LEVEL_MID, 16'h00FF);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();

    // led count above the ring size
    write_reg(rwpg_pkg::CFG_LED_COUNT, 16'd127);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();

    // move the wave, then shrink the ring below its position
    write_reg(rwpg_pkg::CFG_LED_COUNT, 16'd8);
    repeat (6) send_tick(1'b0);
    settle();
    write_reg(rwpg_pkg::CFG_LED_COUNT, 16'd3);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();

    // counted interval with a restart in the middle
    write_reg(rwpg_pkg::CFG_FRAME_INTERVAL, 16'd3);
    write_reg(rwpg_pkg::CFG_LED_COUNT, 16'd64);
    repeat (4) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();

    phase = 0;
    while (sent < STIM_ITEMS) begin
      settle();
      shuffle_config(phase == 0);
      in_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 17;
      out_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
      phase_len = $urandom_range(20, 50);
      for (int k = 0; k < phase_len; k++) begin
        if (k == phase_len / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) begin
          in_ch.valid = 1'b0;
          drain();
        end
        send_tick($urandom_range(0, 19) < 3);
      end
      phase++;
    end

    in_ch.valid = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (board.mismatches == 0) begin
      $display("ring_wave_pixel_generator verification clean");
    end else begin
      $display("ring_wave_pixel_generator verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
